### rtl/core/wraparound_min_path_cost_core_defines.svh
// Assertion macros used by the checker module.
`ifndef WRAPAROUND_MIN_PATH_COST_CORE_DEFINES_SVH
`define WRAPAROUND_MIN_PATH_COST_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define WMPC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define WMPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/wmpc_pkg.sv
package wmpc_pkg;

  localparam int VALUE_W          = 16;
  localparam int COST_W           = 32;
  localparam int ROW_COUNT_W      = 7;
  localparam int END_ROW_W        = 6;
  localparam int IN_TDATA_W       = 16;
  localparam int OUT_TDATA_W      = 40;
  localparam int MAX_ROWS_DEFAULT = 64;

  typedef logic signed [COST_W-1:0]  cost_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [1:0]                kind_t;

  localparam cost_t COST_MAX = {1'b0, {(COST_W-1){1'b1}}};
  localparam cost_t COST_MIN = {1'b1, {(COST_W-1){1'b0}}};

  // Position of a cell within its column, picks where the three neighbors come from
  localparam kind_t KIND_SINGLE = 2'd0;
  localparam kind_t KIND_TOP    = 2'd1;
  localparam kind_t KIND_MID    = 2'd2;
  localparam kind_t KIND_BOTTOM = 2'd3;

  typedef struct packed {
    kind_t kind;
    logic  first;     // cell of the first column of a matrix
    logic  end_col;   // last row of the column
    logic  last_col;  // final-column flag of the item
  } wmpc_ctrl_t;

  function automatic cost_t sat_add(cost_t a, value_t b);
    logic signed [COST_W+1:0] s;
    s = {{2{a[COST_W-1]}}, a} + {{(COST_W+2-VALUE_W){b[VALUE_W-1]}}, b};
    if (s[COST_W+1:COST_W-1] == 3'b000 || s[COST_W+1:COST_W-1] == 3'b111) begin
      return s[COST_W-1:0];
    end else if (s[COST_W+1]) begin
      return COST_MIN;
    end else begin
      return COST_MAX;
    end
  endfunction

endpackage

### rtl/core/wmpc_ram.sv
module wmpc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

### rtl/core/wmpc_front.sv
module wmpc_front #(
  parameter int MAX_ROWS = wmpc_pkg::MAX_ROWS_DEFAULT,
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int AW = RW + 1
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [wmpc_pkg::ROW_COUNT_W-1:0]   cfg_data,
  input  logic                               accept,
  input  logic                               in_last_column,
  input  logic                               s1_valid,
  input  logic [AW-1:0]                      s1_waddr,
  output wmpc_pkg::wmpc_ctrl_t               ctrl,
  output logic [RW-1:0]                      row,
  output logic [AW-1:0]                      waddr,
  output logic [AW-1:0]                      raddr_a,
  output logic [AW-1:0]                      raddr_b,
  output logic                               fwd_a,
  output logic                               fwd_b
);

  import wmpc_pkg::*;

  localparam int CW = $clog2(MAX_ROWS + 1);

  logic [ROW_COUNT_W-1:0] row_count;
  logic [RW-1:0]          row_position;
  logic                   bank;
  logic                   first_column;

  logic [CW-1:0] rows_eff;
  logic [RW-1:0] last_idx;
  logic [RW-1:0] idx_a;
  logic [RW-1:0] idx_b;
  logic          at_last;
  kind_t         kind;

  always_comb begin
    priority if (row_count == '0) begin
      rows_eff = CW'(1);
    end else if (32'(row_count) > 32'(MAX_ROWS)) begin
      rows_eff = CW'(MAX_ROWS);
    end else begin
      rows_eff = CW'(row_count);
    end
    last_idx = RW'(rows_eff - CW'(1));
    // a shrunk row count ends the column at the new last row
    row      = (row_position > last_idx) ? last_idx : row_position;
    at_last  = (row == last_idx);

    priority if (last_idx == '0) begin
      kind = KIND_SINGLE;
    end else if (row == '0) begin
      kind = KIND_TOP;
    end else if (at_last) begin
      kind = KIND_BOTTOM;
    end else begin
      kind = KIND_MID;
    end

    unique case (kind)
      KIND_TOP: begin
        idx_a = last_idx;
        idx_b = RW'(1);
      end
      KIND_MID: begin
        idx_a = row + RW'(1);
        idx_b = row;
      end
      KIND_BOTTOM: begin
        idx_a = row - RW'(1);
        idx_b = row;
      end
      KIND_SINGLE: begin
        idx_a = row;
        idx_b = row;
      end
    endcase
  end

  assign raddr_a = {~bank, idx_a};
  assign raddr_b = {~bank, idx_b};
  assign waddr   = {bank, row};
  // the item ahead writes at the same edge these reads are taken
  assign fwd_a   = s1_valid && (raddr_a == s1_waddr);
  assign fwd_b   = s1_valid && (raddr_b == s1_waddr);
  assign ctrl    = '{kind: kind, first: first_column, end_col: at_last,
                     last_col: in_last_column};

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= ROW_COUNT_W'(1);
      row_position <= '0;
      bank         <= 1'b0;
      first_column <= 1'b1;
    end else begin
      if (cfg_we) begin
        row_count <= cfg_data;
      end
      if (accept) begin
        if (at_last) begin
          row_position <= '0;
          bank         <= ~bank;
          first_column <= in_last_column;
        end else begin
          row_position <= row + RW'(1);
        end
      end
    end
  end

endmodule

### rtl/core/wmpc_cost.sv
module wmpc_cost #(
  parameter int MAX_ROWS = wmpc_pkg::MAX_ROWS_DEFAULT,
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  localparam int AW = RW + 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  wmpc_pkg::value_t                  cell_value,
  input  wmpc_pkg::wmpc_ctrl_t              ctrl_in,
  input  logic [RW-1:0]                     row_in,
  input  logic [AW-1:0]                     waddr_in,
  input  logic                              fwd_a_in,
  input  logic                              fwd_b_in,
  input  wmpc_pkg::cost_t                   rd_a,
  input  wmpc_pkg::cost_t                   rd_b,
  input  logic                              m_tready,
  output logic                              advance,
  output logic                              s1_valid,
  output logic [AW-1:0]                     s1_waddr,
  output logic                              we,
  output wmpc_pkg::cost_t                   wdata,
  output logic                              m_tvalid,
  output wmpc_pkg::cost_t                   min_cost,
  output logic [wmpc_pkg::END_ROW_W-1:0]    end_row
);

  import wmpc_pkg::*;

  wmpc_ctrl_t    s1_ctrl;
  logic [RW-1:0] s1_row;
  value_t        s1_value;
  logic          s1_fwd_a;
  logic          s1_fwd_b;

  cost_t         fwd_cost;
  cost_t         win_mid;
  cost_t         win_dn;
  cost_t         prev_row0;
  cost_t         cur_row0;
  cost_t         best_cost;
  logic [RW-1:0] best_row;

  cost_t         pa;
  cost_t         pb;
  cost_t         up;
  cost_t         mid;
  cost_t         dn;
  cost_t         m;
  cost_t         cost;
  cost_t         nb_cost;
  logic [RW-1:0] nb_row;
  logic          emit;
  logic          fire;

  always_comb begin
    pa = s1_fwd_a ? fwd_cost : rd_a;
    pb = s1_fwd_b ? fwd_cost : rd_b;
    // middle rows reuse what the previous row already fetched
    unique case (s1_ctrl.kind)
      KIND_TOP: begin
        up  = pa;
        mid = prev_row0;
        dn  = pb;
      end
      KIND_MID: begin
        up  = win_mid;
        mid = win_dn;
        dn  = pa;
      end
      KIND_BOTTOM: begin
        up  = pa;
        mid = pb;
        dn  = prev_row0;
      end
      KIND_SINGLE: begin
        up  = prev_row0;
        mid = prev_row0;
        dn  = prev_row0;
      end
    endcase
    m = mid;
    if (up < m) begin
      m = up;
    end
    if (dn < m) begin
      m = dn;
    end
    if (s1_ctrl.first) begin
      cost = {{(COST_W-VALUE_W){s1_value[VALUE_W-1]}}, s1_value};
    end else begin
      cost = sat_add(m, s1_value);
    end
    if (s1_row == '0 || cost < best_cost) begin
      nb_cost = cost;
      nb_row  = s1_row;
    end else begin
      nb_cost = best_cost;
      nb_row  = best_row;
    end
  end

  assign emit    = s1_ctrl.end_col && s1_ctrl.last_col;
  assign advance = !s1_valid || !emit || !m_tvalid || m_tready;
  assign fire    = s1_valid && advance;
  assign we      = fire;
  assign wdata   = cost;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      m_tvalid  <= 1'b0;
      best_cost <= COST_MAX;
      best_row  <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (fire && emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (fire) begin
        if (emit) begin
          best_cost <= COST_MAX;
          best_row  <= '0;
        end else begin
          best_cost <= nb_cost;
          best_row  <= nb_row;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctrl  <= ctrl_in;
      s1_row   <= row_in;
      s1_value <= cell_value;
      s1_waddr <= waddr_in;
      s1_fwd_a <= fwd_a_in;
      s1_fwd_b <= fwd_b_in;
    end
    if (fire) begin
      fwd_cost <= cost;
      win_mid  <= mid;
      win_dn   <= dn;
      if (s1_row == '0) begin
        cur_row0 <= cost;
      end
      if (s1_ctrl.end_col) begin
        prev_row0 <= (s1_row == '0) ? cost : cur_row0;
      end
      if (emit) begin
        min_cost <= nb_cost;
        end_row  <= END_ROW_W'(nb_row);
      end
    end
  end

endmodule

### rtl/core/wraparound_min_path_cost_core.sv
// Minimum path cost over a matrix whose columns arrive one after another, rows wrapping.
// Input stream s_*: one matrix cell per item, column-major, rows 0..R-1 of each column.
//   s_tdata carries the signed cell value, s_tuser marks cells of the final column.
// Config channel cfg_*: writes the row count R (0 acts as 1, values above MAX_ROWS
//   act as MAX_ROWS); write only while no item is in flight.
// Output stream m_*: one item per matrix, after the last row of the final column,
//   holding the least saturated path cost and the lowest row that reaches it.
// Throughput: one cell per cycle unless stalled (see Stall). The compute stage takes
//   the previous column's neighbors from a two-bank cost RAM with two read ports;
//   the final cell of a matrix is registered into the compute stage, and from there
//   its result loads the result register and raises m_tvalid.
// Stall: the result register holds while m_tready is low; s_tready drops during reset
//   and when the cell in the compute stage has a result to deliver while that
//   register is still full and held.
// Reset clears the row position, bank, first-column flag and best-cost tracking and
//   sets R to 1; cost RAM contents are not cleared and are never used before written.
module wraparound_min_path_cost_core #(
  parameter int MAX_ROWS = wmpc_pkg::MAX_ROWS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [wmpc_pkg::IN_TDATA_W-1:0]     s_tdata,   // [15:0] cell_value
  input  logic [0:0]                          s_tuser,   // [0] in_last_column
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [wmpc_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [31:0] min_cost, [37:32] end_row
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wmpc_pkg::ROW_COUNT_W-1:0]    cfg_data
);

  import wmpc_pkg::*;

  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int AW    = RW + 1;
  localparam int DEPTH = 2 << RW;

  wmpc_ctrl_t           ctrl;
  logic [RW-1:0]        row;
  logic [AW-1:0]        waddr;
  logic [AW-1:0]        raddr_a;
  logic [AW-1:0]        raddr_b;
  logic                 fwd_a;
  logic                 fwd_b;
  logic                 advance;
  logic                 accept;
  logic                 s1_valid;
  logic [AW-1:0]        s1_waddr;
  logic                 we;
  cost_t                wdata;
  cost_t                rd_a;
  cost_t                rd_b;
  cost_t                min_cost;
  logic [END_ROW_W-1:0] end_row;

  assign s_tready  = advance && !rst;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = !rst;
  assign m_tdata   = {{(OUT_TDATA_W-COST_W-END_ROW_W){1'b0}}, end_row, min_cost};

  wmpc_front #(
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_data       (cfg_data),
    .accept         (accept),
    .in_last_column (s_tuser[0]),
    .s1_valid       (s1_valid),
    .s1_waddr       (s1_waddr),
    .ctrl           (ctrl),
    .row            (row),
    .waddr          (waddr),
    .raddr_a        (raddr_a),
    .raddr_b        (raddr_b),
    .fwd_a          (fwd_a),
    .fwd_b          (fwd_b)
  );

  wmpc_ram #(
    .WIDTH (COST_W),
    .DEPTH (DEPTH)
  ) u_cost_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (s1_waddr),
    .wdata   (wdata),
    .re      (accept),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  wmpc_cost #(
    .MAX_ROWS (MAX_ROWS)
  ) u_cost (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .cell_value ($signed(s_tdata[VALUE_W-1:0])),
    .ctrl_in    (ctrl),
    .row_in     (row),
    .waddr_in   (waddr),
    .fwd_a_in   (fwd_a),
    .fwd_b_in   (fwd_b),
    .rd_a       (rd_a),
    .rd_b       (rd_b),
    .m_tready   (m_tready),
    .advance    (advance),
    .s1_valid   (s1_valid),
    .s1_waddr   (s1_waddr),
    .we         (we),
    .wdata      (wdata),
    .m_tvalid   (m_tvalid),
    .min_cost   (min_cost),
    .end_row    (end_row)
  );

endmodule

### rtl/core/wmpc_checker.sv
`include "wraparound_min_path_cost_core_defines.svh"

module wmpc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [wmpc_pkg::OUT_TDATA_W-1:0]  m_tdata
);

  import wmpc_pkg::*;

  `WMPC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result item changed while stalled")
  `WMPC_ASSERT_SAME(a_ready_when_out_free, !m_tvalid, s_tready, "input stalled with empty result register")
  `WMPC_ASSERT_SAME(a_result_latency, $rose(m_tvalid), $past(s_tvalid && s_tready, 2), "result item without a cell two cycles earlier")
  `WMPC_ASSERT_SAME(a_pad_zero, m_tvalid, m_tdata[OUT_TDATA_W-1:COST_W+END_ROW_W] == '0, "nonzero padding in result item")

endmodule

bind wraparound_min_path_cost_core wmpc_checker u_checker (.*);
